>>> rtl/bmp_pixel_row_decoder_top_defines.svh
// assertion macros shared by the bmp pixel row decoder
`ifndef BMP_PIXEL_ROW_DECODER_TOP_DEFINES_SVH
`define BMP_PIXEL_ROW_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked while out of reset
`define BPR_ASSERT_DIS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked at every edge, reset included
`define BPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPR_ASSERT_DIS(lbl, clk, rst_n, prop, msg)
`define BPR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/bpr_pkg.sv
// types and constants of the bmp pixel row decoder
package bpr_pkg;

    localparam int DEF_PALETTE_DEPTH = 256;
    localparam int DEF_MAX_WIDTH     = 4096;
    localparam int DEF_MAX_HEIGHT    = 4096;

    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int POS_W       = 12;

    // register indexes (byte address 4*index)
    localparam logic [1:0] REG_DEPTH  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [2:0]  DEPTH_RESET  = 3'd3;
    localparam logic [12:0] DIM_RESET    = 13'd1;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [2:0] {
        DEPTH_1  = 3'd0,
        DEPTH_4  = 3'd1,
        DEPTH_8  = 3'd2,
        DEPTH_24 = 3'd3,
        DEPTH_32 = 3'd4
    } depth_t;

    typedef enum logic [1:0] {
        JOB_PALETTE,
        JOB_INDEXED,
        JOB_DIRECT
    } job_kind_t;

    typedef struct packed {
        logic        mode;
        logic [7:0]  palette_index;
        logic [31:0] palette_word;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic [POS_W-1:0] pixel_column;
        logic [POS_W-1:0] pixel_row;
        logic             frame_end;
        logic             run_last;
    } out_item_t;

    // one classified item between front and back
    typedef struct packed {
        job_kind_t        kind;
        depth_t           depth;
        logic [7:0]       index_byte;
        logic [31:0]      word;
        logic [7:0]       pal_addr;
        logic [2:0]       last_k;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic             frame_end;
    } job_t;

    typedef struct packed {
        depth_t depth;
        logic   restart;
    } cfg_ctl_t;

endpackage

>>> rtl/bpr_ram.sv
// generic single-write, single-read ram with registered read data
module bpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bpr_cfg.sv
// configuration registers and derived image settings
module bpr_cfg #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int COL_W      = 13,
    parameter int ROW_W      = 13
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpr_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bpr_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [bpr_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output bpr_pkg::cfg_ctl_t               ctl,
    output logic [COL_W-1:0]                eff_width,
    output logic [ROW_W-1:0]                eff_height
);
    import bpr_pkg::*;

    logic [2:0]  depth_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [1:0]  reg_index;
    logic        wr_en;

    assign reg_index = paddr[CFG_ADDR_W-1:2];
    assign wr_en     = psel & penable & pwrite;
    assign pready    = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg  <= DEPTH_RESET;
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_DEPTH:  depth_reg  <= pwdata[2:0];
                REG_WIDTH:  width_reg  <= pwdata[12:0];
                REG_HEIGHT: height_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_index)
            REG_DEPTH:  prdata = CFG_DATA_W'(depth_reg);
            REG_WIDTH:  prdata = CFG_DATA_W'(width_reg);
            REG_HEIGHT: prdata = CFG_DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // any write to a known register restarts the frame
    always_comb begin
        ctl.restart = wr_en && (reg_index == REG_DEPTH || reg_index == REG_WIDTH ||
                                reg_index == REG_HEIGHT);
        priority if (depth_reg > DEPTH_32) begin
            ctl.depth = DEPTH_32;
        end else begin
            ctl.depth = depth_t'(depth_reg);
        end
    end

    // clamp width and height into their legal range
    always_comb begin
        priority if (width_reg == '0) begin
            eff_width = COL_W'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            eff_width = COL_W'(MAX_WIDTH);
        end else begin
            eff_width = COL_W'(width_reg);
        end
        priority if (height_reg == '0) begin
            eff_height = ROW_W'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            eff_height = ROW_W'(MAX_HEIGHT);
        end else begin
            eff_height = ROW_W'(height_reg);
        end
    end

endmodule

>>> rtl/bpr_front.sv
// front end: accepts items, tracks row position and gathers direct-color pixels
module bpr_front #(
    parameter int COL_W = 13,
    parameter int ROW_W = 13
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bpr_pkg::in_item_t  s_item,
    input  bpr_pkg::cfg_ctl_t  ctl,
    input  logic [COL_W-1:0]   eff_width,
    input  logic [ROW_W-1:0]   eff_height,
    input  logic               q_full,
    output logic               q_push,
    output bpr_pkg::job_t      q_job
);
    import bpr_pkg::*;

    localparam int RB_W = COL_W + 3;

    logic [RB_W-1:0]  rbc_reg, rbc_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [23:0]      partial_reg, partial_next;
    logic [1:0]       bip_reg, bip_next;

    logic [COL_W+4:0] row_bits;
    logic [COL_W+5:0] row_bits_rnd;
    logic [RB_W-1:0]  row_bytes;
    logic [RB_W-1:0]  rbc_inc;
    logic [COL_W:0]   remaining;
    logic [3:0]       per_byte;
    logic [3:0]       n_pix;
    logic             in_row;
    logic             is_indexed;
    logic             row_last;
    logic             row_done;
    logic [1:0]       bip_last;
    logic             pixel_done;
    logic [23:0]      partial_or;
    logic [7:0]       alpha;
    logic             accept;
    logic             data_accept;

    assign s_ready     = !q_full;
    assign accept      = s_valid & s_ready;
    assign data_accept = accept & s_item.mode;

    // padded row length in bytes
    always_comb begin
        unique case (ctl.depth)
            DEPTH_1:  row_bits = (COL_W+5)'(eff_width);
            DEPTH_4:  row_bits = (COL_W+5)'(eff_width) << 2;
            DEPTH_8:  row_bits = (COL_W+5)'(eff_width) << 3;
            DEPTH_24: row_bits = ((COL_W+5)'(eff_width) << 4) + ((COL_W+5)'(eff_width) << 3);
            default:  row_bits = (COL_W+5)'(eff_width) << 5;
        endcase
        row_bits_rnd = (COL_W+6)'(row_bits) + (COL_W+6)'(31);
        row_bytes    = {row_bits_rnd[COL_W+5:5], 2'b00};
    end

    // classification of the byte
    always_comb begin
        is_indexed = (ctl.depth == DEPTH_1) || (ctl.depth == DEPTH_4) || (ctl.depth == DEPTH_8);
        unique case (ctl.depth)
            DEPTH_1: per_byte = 4'd8;
            DEPTH_4: per_byte = 4'd2;
            default: per_byte = 4'd1;
        endcase
        in_row    = col_reg < eff_width;
        remaining = {1'b0, eff_width} - {1'b0, col_reg};
        if (remaining >= (COL_W+1)'(per_byte)) begin
            n_pix = per_byte;
        end else begin
            n_pix = remaining[3:0];
        end
        row_last   = row_reg == (eff_height - ROW_W'(1));
        bip_last   = (ctl.depth == DEPTH_24) ? 2'd2 : 2'd3;
        pixel_done = bip_reg == bip_last;
        partial_or = partial_reg | 24'({16'b0, s_item.data_byte} << {bip_reg, 3'b000});
        alpha      = (ctl.depth == DEPTH_24) ? ALPHA_OPAQUE : s_item.data_byte;
        rbc_inc    = rbc_reg + RB_W'(1);
        row_done   = rbc_inc >= row_bytes;
    end

    // job toward the back end
    always_comb begin
        q_push = accept && (!s_item.mode || (in_row && (is_indexed || pixel_done)));
        q_job.depth      = ctl.depth;
        q_job.index_byte = s_item.data_byte;
        q_job.pal_addr   = s_item.palette_index;
        q_job.last_k     = 3'(n_pix - 4'd1);
        q_job.column     = POS_W'(col_reg);
        q_job.row        = POS_W'(row_reg);
        if (!s_item.mode) begin
            q_job.kind      = JOB_PALETTE;
            q_job.word      = s_item.palette_word;
            q_job.frame_end = 1'b0;
        end else if (is_indexed) begin
            q_job.kind      = JOB_INDEXED;
            q_job.word      = s_item.palette_word;
            q_job.frame_end = row_last && (remaining == (COL_W+1)'(n_pix));
        end else begin
            q_job.kind      = JOB_DIRECT;
            q_job.word      = {alpha, partial_or};
            q_job.frame_end = row_last && (remaining == (COL_W+1)'(1));
        end
    end

    // position and partial pixel update
    always_comb begin
        rbc_next     = rbc_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        partial_next = partial_reg;
        bip_next     = bip_reg;
        if (ctl.restart) begin
            rbc_next     = '0;
            col_next     = '0;
            row_next     = '0;
            partial_next = '0;
            bip_next     = '0;
        end else if (data_accept) begin
            if (row_done) begin
                rbc_next     = '0;
                col_next     = '0;
                partial_next = '0;
                bip_next     = '0;
                row_next     = row_last ? '0 : row_reg + ROW_W'(1);
            end else begin
                rbc_next = rbc_inc;
                if (in_row) begin
                    if (is_indexed) begin
                        col_next = col_reg + COL_W'(n_pix);
                    end else if (pixel_done) begin
                        col_next     = col_reg + COL_W'(1);
                        partial_next = '0;
                        bip_next     = '0;
                    end else begin
                        partial_next = partial_or;
                        bip_next     = bip_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rbc_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            partial_reg <= '0;
            bip_reg     <= '0;
        end else begin
            rbc_reg     <= rbc_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            partial_reg <= partial_next;
            bip_reg     <= bip_next;
        end
    end

endmodule

>>> rtl/bpr_queue.sv
// short job queue between front and back
module bpr_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bpr_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output bpr_pkg::job_t head_job
);
    import bpr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = count_reg == CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/bpr_back.sv
// back end: palette writes, index unpacking and lookup, output register
module bpr_back #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             head_valid,
    input  bpr_pkg::job_t                    head_job,
    output logic                             pop,
    output logic                             ram_we,
    output logic [$clog2(PALETTE_DEPTH)-1:0] ram_waddr,
    output logic [31:0]                      ram_wdata,
    output logic                             ram_re,
    output logic [$clog2(PALETTE_DEPTH)-1:0] ram_raddr,
    input  logic [31:0]                      ram_rdata,
    output logic                             m_valid,
    input  logic                             m_ready,
    output bpr_pkg::out_item_t               m_item
);
    import bpr_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [2:0]       k_reg;
    logic             s1_valid_reg;
    logic             s1_indexed_reg;
    logic             s1_oob_reg;
    logic [31:0]      s1_word_reg;
    logic [POS_W-1:0] s1_col_reg;
    logic [POS_W-1:0] s1_row_reg;
    logic             s1_fe_reg;
    logic             s1_last_reg;
    logic             m_valid_reg;
    out_item_t        m_item_reg;

    logic             out_free;
    logic             s1_move;
    logic             s1_free;
    logic             is_pal;
    logic             issue;
    logic             elem_last;
    logic [7:0]       pix_index;
    logic             oob;
    logic [31:0]      color;

    // pipeline flow
    always_comb begin
        out_free  = !m_valid_reg || m_ready;
        s1_move   = s1_valid_reg && out_free;
        s1_free   = !s1_valid_reg || out_free;
        is_pal    = head_valid && (head_job.kind == JOB_PALETTE);
        issue     = head_valid && (head_job.kind != JOB_PALETTE) && s1_free;
        elem_last = (head_job.kind == JOB_DIRECT) || (k_reg == head_job.last_k);
        pop       = is_pal || (issue && elem_last);
    end

    // index of the current element, most significant first
    always_comb begin
        unique case (head_job.depth)
            DEPTH_1: pix_index = {7'b0, head_job.index_byte[3'd7 - k_reg]};
            DEPTH_4: pix_index = k_reg[0] ? {4'b0, head_job.index_byte[3:0]}
                                          : {4'b0, head_job.index_byte[7:4]};
            default: pix_index = head_job.index_byte;
        endcase
        oob = {1'b0, pix_index} >= 9'(PALETTE_DEPTH);
    end

    // palette port
    always_comb begin
        ram_we    = is_pal && ({1'b0, head_job.pal_addr} < 9'(PALETTE_DEPTH));
        ram_waddr = head_job.pal_addr[AW-1:0];
        ram_wdata = head_job.word;
        ram_re    = issue && (head_job.kind == JOB_INDEXED);
        ram_raddr = pix_index[AW-1:0];
    end

    // element counter and lookup stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (issue) begin
                k_reg <= elem_last ? 3'd0 : k_reg + 3'd1;
            end
            s1_valid_reg <= issue || (s1_valid_reg && !s1_move);
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_indexed_reg <= head_job.kind == JOB_INDEXED;
            s1_oob_reg     <= oob;
            s1_word_reg    <= head_job.word;
            s1_col_reg     <= head_job.column + POS_W'(k_reg);
            s1_row_reg     <= head_job.row;
            s1_fe_reg      <= head_job.frame_end && elem_last;
            s1_last_reg    <= elem_last;
        end
    end

    // output register
    always_comb begin
        if (s1_indexed_reg) begin
            color = s1_oob_reg ? 32'd0 : ram_rdata;
        end else begin
            color = s1_word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= s1_move || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_item_reg.alpha        <= color[31:24];
            m_item_reg.red          <= color[23:16];
            m_item_reg.green        <= color[15:8];
            m_item_reg.blue         <= color[7:0];
            m_item_reg.pixel_column <= s1_col_reg;
            m_item_reg.pixel_row    <= s1_row_reg;
            m_item_reg.frame_end    <= s1_fe_reg;
            m_item_reg.run_last     <= s1_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

>>> rtl/bmp_pixel_row_decoder_top.sv
// top level of the bmp pixel row decoder
//
// Input channel s_*: one transfer per item. mode 0 writes palette entry
// palette_index with palette_word; mode 1 carries the next byte of the bmp
// pixel array. Output channel m_*: one transfer per decoded pixel with its
// color, column, row, frame_end on the last pixel of the image and run_last
// on the last pixel caused by an input byte. Padding bytes and pixels past
// the image width give no output.
// Configuration sits on the apb port: depth code at 0x0, width at 0x4,
// height at 0x8; a write to any of them restarts the frame.
// Throughput: one input transfer per cycle into a four-entry job queue
// while it has room, and one pixel per cycle out of the back end while the
// receiver is ready, so at 1 and 4 bits per pixel the output channel (up to
// 8 pixels per byte) sets the pace.
// Reset clears the row and column position, the queue and the pipeline; the
// palette keeps undefined contents until written. When the receiver stalls
// the output register holds, the lookup stage and queue fill, and s_ready
// falls once the queue is full.
`include "bmp_pixel_row_decoder_top_defines.svh"

module bmp_pixel_row_decoder_top #(
    parameter int PALETTE_DEPTH = bpr_pkg::DEF_PALETTE_DEPTH,
    parameter int MAX_WIDTH     = bpr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = bpr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  bpr_pkg::in_item_t               s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output bpr_pkg::out_item_t              m_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpr_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bpr_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [bpr_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import bpr_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
    localparam int AW    = $clog2(PALETTE_DEPTH);

    cfg_ctl_t         ctl;
    logic [COL_W-1:0] eff_width;
    logic [ROW_W-1:0] eff_height;

    logic             q_push;
    logic             q_full;
    job_t             q_job;
    logic             q_pop;
    logic             q_head_valid;
    job_t             q_head_job;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [31:0]      ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [31:0]      ram_rdata;

    // configuration registers
    bpr_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .ctl        (ctl),
        .eff_width  (eff_width),
        .eff_height (eff_height)
    );

    // byte classification and position tracking
    bpr_front #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .ctl        (ctl),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (q_job)
    );

    // job queue
    bpr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    // palette memory
    bpr_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // pixel generation
    bpr_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

    // checks
    `BPR_ASSERT_DIS(a_pop_needs_job, aclk, aresetn, q_pop |-> q_head_valid, "queue popped while empty")
    `BPR_ASSERT_DIS(a_palette_port, aclk, aresetn, !(ram_we && ram_re), "palette read and write in one cycle")
    `BPR_ASSERT_DIS(a_frame_end_last, aclk, aresetn, (m_valid && m_item.frame_end) |-> m_item.run_last, "frame end not on last pixel of its byte")
    `BPR_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (!m_valid && !q_head_valid), "pipeline not empty after reset")

endmodule
